// ===== design/glit_pkg.sv =====
// shared types and constants for the goal line intercept tracker
`timescale 1ns / 1ps

package glit_pkg;

    // field and register widths
    localparam int IN_W       = 16;
    localparam int THR_W      = 15;
    localparam int SPD_W      = 8;
    localparam int MINP_W     = 8;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int PRED_W     = 16;
    localparam int ACT_W      = 2;
    localparam int DIR_W      = 4;
    localparam int WORD_W     = 16;

    // running sum widths
    localparam int SUMX_W = 24;
    localparam int SUMY_W = 24;
    localparam int SY2_W  = 38;
    localparam int SXY_W  = 40;
    localparam int CNT_W  = 8;
    localparam int PROD_W = 32;

    // fit arithmetic
    localparam int OPA_W    = 24;
    localparam int OPB_W    = 40;
    localparam int HALF_W   = 20;
    localparam int PART_W   = OPA_W + HALF_W + 1;
    localparam int ACC_W    = 64;
    localparam int DEN_W    = 48;
    localparam int DIVD_W   = 64;
    localparam int DIVS_W   = 48;
    localparam int STEP_W   = 4;
    localparam int MUL_STEPS = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS     = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 15'd32;
    localparam logic [SPD_W-1:0]  SPD_RESET  = 8'd250;
    localparam logic [MINP_W-1:0] MINP_RESET = 8'd5;

    // actions and motor codes
    localparam logic [ACT_W-1:0] ACT_HOLD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd2;

    localparam logic [DIR_W-1:0] DIR_STOP    = 4'h0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 4'h9;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 4'h6;

    localparam logic [SPD_W-1:0] SPEED_LIMIT = 8'd250;
    localparam int FAIL_POS = -16;
    localparam logic [CNT_W-1:0] FIT_MIN_POINTS = 8'd3;

    localparam int QUEUE_DEPTH = 2;

    // parameter defaults
    localparam int MAX_POINTS_DEF = 255;
    localparam int POS_WIDTH_DEF  = 16;

    typedef struct packed {
        logic [THR_W-1:0]  move_threshold;
        logic [SPD_W-1:0]  drive_speed;
        logic [MINP_W-1:0] min_points;
    } cfg_t;

    typedef struct packed {
        logic signed [SUMX_W-1:0] sum_x;
        logic signed [SUMY_W-1:0] sum_y;
        logic [SY2_W-1:0]         sum_y_sq;
        logic signed [SXY_W-1:0]  sum_xy;
        logic [CNT_W-1:0]         count;
    } snap_t;

endpackage

// ===== design/goal_line_intercept_tracker_unit.sv =====
// front end takes a new request after F_MUL, F_ACC and F_PUSH, or F_MUL alone if depth is at or below zero
// a request that yields a fit raises out_valid after the front states, the queue pop, the multiply
// steps, the divide setup, the divide steps and the decision state
// the back end pops a new job only once the previous result is loaded; each fit waits on the one-bit-per-cycle divider
// a two-entry job queue lets the front end keep accepting while a fit is in progress
// asynchronous active-low reset clears sums, count, keeper position and loads register defaults
`timescale 1ns / 1ps

module goal_line_intercept_tracker_unit #(
    parameter int MAX_POINTS = glit_pkg::MAX_POINTS_DEF,
    parameter int POS_WIDTH  = glit_pkg::POS_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [glit_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [glit_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [glit_pkg::IN_W-1:0]     ball_x,
    input  logic signed [glit_pkg::IN_W-1:0]     ball_depth,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [glit_pkg::PRED_W-1:0]   predicted_x,
    output logic                                 fit_ok,
    output logic [glit_pkg::ACT_W-1:0]           action,
    output logic [glit_pkg::DIR_W-1:0]           dir_code,
    output logic [glit_pkg::WORD_W-1:0]          speed_word
);

    glit_pkg::cfg_t  cfg_reg;
    glit_pkg::snap_t push_data;
    glit_pkg::snap_t pop_data;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_threshold <= glit_pkg::THR_RESET;
            cfg_reg.drive_speed    <= glit_pkg::SPD_RESET;
            cfg_reg.min_points     <= glit_pkg::MINP_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                glit_pkg::REG_MOVE_THRESHOLD:
                begin
                    cfg_reg.move_threshold <= cfg_data[glit_pkg::THR_W-1:0];
                end
                glit_pkg::REG_DRIVE_SPEED:
                begin
                    cfg_reg.drive_speed <= cfg_data[glit_pkg::SPD_W-1:0];
                end
                glit_pkg::REG_MIN_POINTS:
                begin
                    cfg_reg.min_points <= cfg_data[glit_pkg::MINP_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    glit_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ball_x     (ball_x),
        .ball_depth (ball_depth),
        .min_points (cfg_reg.min_points),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data)
    );

    glit_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    glit_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .predicted_x (predicted_x),
        .fit_ok      (fit_ok),
        .action      (action),
        .dir_code    (dir_code),
        .speed_word  (speed_word)
    );

endmodule

// ===== design/glit_front.sv =====
// front end: takes observations, keeps the running sums, queues fit jobs
`timescale 1ns / 1ps

module glit_front #(
    parameter int MAX_POINTS = glit_pkg::MAX_POINTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [glit_pkg::IN_W-1:0]     ball_x,
    input  logic signed [glit_pkg::IN_W-1:0]     ball_depth,
    input  logic [glit_pkg::MINP_W-1:0]          min_points,
    input  logic                                 q_full,
    output logic                                 q_push,
    output glit_pkg::snap_t                      q_data
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_ACC  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    localparam logic [glit_pkg::CNT_W-1:0] MAX_CNT = glit_pkg::CNT_W'(MAX_POINTS);

    logic [1:0] state_reg, state_next;

    logic signed [glit_pkg::SUMX_W-1:0] sum_x_reg, sum_x_next;
    logic signed [glit_pkg::SUMY_W-1:0] sum_y_reg, sum_y_next;
    logic [glit_pkg::SY2_W-1:0]         sum_y_sq_reg, sum_y_sq_next;
    logic signed [glit_pkg::SXY_W-1:0]  sum_xy_reg, sum_xy_next;
    logic [glit_pkg::CNT_W-1:0]         count_reg, count_next;

    logic signed [glit_pkg::IN_W-1:0]   x_reg;
    logic signed [glit_pkg::IN_W-1:0]   y_reg;
    logic signed [glit_pkg::PROD_W-1:0] xy_reg;
    logic signed [glit_pkg::PROD_W-1:0] yy_reg;

    logic y_nonpos;

    assign in_ready = (state_reg == F_IDLE);
    assign y_nonpos = y_reg[glit_pkg::IN_W-1] || (y_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        sum_y_sq_next = sum_y_sq_reg;
        sum_xy_next   = sum_xy_reg;
        count_next    = count_reg;
        q_push        = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                // depth at or behind the line restarts the track
                if (y_nonpos)
                begin
                    sum_x_next    = '0;
                    sum_y_next    = '0;
                    sum_y_sq_next = '0;
                    sum_xy_next   = '0;
                    count_next    = '0;
                    state_next    = F_IDLE;
                end
                else
                begin
                    state_next = F_ACC;
                end
            end
            F_ACC:
            begin
                if (count_reg < MAX_CNT)
                begin
                    sum_x_next    = sum_x_reg + glit_pkg::SUMX_W'(x_reg);
                    sum_y_next    = sum_y_reg + glit_pkg::SUMY_W'(y_reg);
                    sum_y_sq_next = sum_y_sq_reg + glit_pkg::SY2_W'($unsigned(yy_reg));
                    sum_xy_next   = sum_xy_reg + glit_pkg::SXY_W'(xy_reg);
                    count_next    = count_reg + 1'b1;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (count_reg >= min_points)
                begin
                    if (!q_full)
                    begin
                        q_push     = 1'b1;
                        state_next = F_IDLE;
                    end
                end
                else
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_data.sum_x    = sum_x_reg;
    assign q_data.sum_y    = sum_y_reg;
    assign q_data.sum_y_sq = sum_y_sq_reg;
    assign q_data.sum_xy   = sum_xy_reg;
    assign q_data.count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_y_sq_reg <= '0;
            sum_xy_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            sum_y_sq_reg <= sum_y_sq_next;
            sum_xy_reg   <= sum_xy_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg <= ball_x;
            y_reg <= ball_depth;
        end
        if (state_reg == F_MUL)
        begin
            xy_reg <= x_reg * y_reg;
            yy_reg <= y_reg * y_reg;
        end
    end

endmodule

// ===== design/glit_queue.sv =====
// short register queue of fit jobs between front and back
`timescale 1ns / 1ps

module glit_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  glit_pkg::snap_t push_data,
    output logic            full,
    input  logic            pop,
    output glit_pkg::snap_t pop_data,
    output logic            empty
);

    localparam int DEPTH = glit_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    glit_pkg::snap_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from an empty queue");

endmodule

// ===== design/glit_div.sv =====
// restoring divider, one quotient bit per cycle, saturating quotient
`timescale 1ns / 1ps

module glit_div #(
    parameter int POS_WIDTH = glit_pkg::POS_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [glit_pkg::DIVD_W-1:0]   dividend,
    input  logic [glit_pkg::DIVS_W-1:0]   divisor,
    output logic                          done,
    output logic [POS_WIDTH-1:0]          quot,
    output logic                          sat
);

    localparam int DW    = glit_pkg::DIVD_W;
    localparam int SW    = glit_pkg::DIVS_W;
    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DW-1:0]        dvd_reg;
    logic [SW-1:0]        dsr_reg;
    logic [SW-1:0]        rem_reg;
    logic [POS_WIDTH-1:0] q_reg;
    logic                 ovf_reg;

    logic [SW:0] rem_sh;
    logic [SW:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, dvd_reg[DW-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};
    assign ge     = (rem_sh >= {1'b0, dsr_reg});

    assign done = done_reg;
    assign quot = q_reg;
    assign sat  = ovf_reg | q_reg[POS_WIDTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            rem_reg <= ge ? diff[SW-1:0] : rem_sh[SW-1:0];
            // any bit shifted past the top means the result saturates
            ovf_reg <= ovf_reg | q_reg[POS_WIDTH-1];
            q_reg   <= {q_reg[POS_WIDTH-2:0], ge};
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

// ===== design/glit_back.sv =====
// back end: least squares intercept, keeper decision and result register
`timescale 1ns / 1ps

module glit_back #(
    parameter int POS_WIDTH = glit_pkg::POS_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  glit_pkg::cfg_t                        cfg,
    input  logic                                  q_empty,
    input  glit_pkg::snap_t                       q_data,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [glit_pkg::PRED_W-1:0]    predicted_x,
    output logic                                  fit_ok,
    output logic [glit_pkg::ACT_W-1:0]            action,
    output logic [glit_pkg::DIR_W-1:0]            dir_code,
    output logic [glit_pkg::WORD_W-1:0]           speed_word
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_DIV0 = 3'd2;
    localparam logic [2:0] B_DIV  = 3'd3;
    localparam logic [2:0] B_DEC  = 3'd4;

    localparam int PW    = POS_WIDTH;
    localparam int CMP_W = (PW + 2 > 16) ? PW + 2 : 16;
    localparam int EXT_W = (PW > glit_pkg::PRED_W) ? PW : glit_pkg::PRED_W;
    localparam int HW    = glit_pkg::HALF_W;
    localparam int OBW   = glit_pkg::OPB_W;
    localparam int AW    = glit_pkg::ACC_W;

    localparam logic [glit_pkg::STEP_W-1:0] NUM_DONE = glit_pkg::STEP_W'(glit_pkg::MUL_STEPS / 2);
    localparam logic [glit_pkg::STEP_W-1:0] DEN_DONE = glit_pkg::STEP_W'(glit_pkg::MUL_STEPS);

    localparam logic signed [PW-1:0] POS_MAX  = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN  = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [PW-1:0] POS_FAIL = PW'(glit_pkg::FAIL_POS);

    logic [2:0] state_reg, state_next;
    logic [glit_pkg::STEP_W-1:0] step_reg;
    logic out_valid_reg;
    logic signed [PW-1:0] keeper_reg;

    glit_pkg::snap_t snap_reg;
    logic signed [glit_pkg::PART_W-1:0] prod_reg;
    logic prod_hi_reg;
    logic prod_neg_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] num_reg;
    logic signed [glit_pkg::DEN_W-1:0] den_reg;
    logic neg_reg;
    logic signed [PW-1:0] pred_reg;
    logic ok_reg;

    logic signed [glit_pkg::PRED_W-1:0] pred_out_reg;
    logic ok_out_reg;
    logic [glit_pkg::ACT_W-1:0] act_out_reg;
    logic [glit_pkg::DIR_W-1:0] dir_out_reg;
    logic [glit_pkg::WORD_W-1:0] word_out_reg;

    // multiply step operands
    logic signed [glit_pkg::OPA_W-1:0] opa;
    logic signed [OBW-1:0] opb;
    logic signed [HW:0] bpart;
    logic signed [AW-1:0] term;
    logic signed [AW-1:0] acc_sum;

    // divide setup
    logic [AW-1:0] num_mag;
    logic [glit_pkg::DEN_W-1:0] den_mag;
    logic fit_fail;
    logic div_start;
    logic div_done;
    logic [PW-1:0] div_q;
    logic div_sat;

    // decision
    logic signed [CMP_W-1:0] err;
    logic [CMP_W-1:0] err_mag;
    logic move;
    logic [glit_pkg::SPD_W-1:0] spd;
    logic signed [EXT_W-1:0] pred_ext;
    logic load_out;

    always_comb
    begin
        unique case (step_reg[2:1])
            2'd0:
            begin
                opa = snap_reg.sum_x;
                opb = $signed(OBW'(snap_reg.sum_y_sq));
            end
            2'd1:
            begin
                opa = snap_reg.sum_y;
                opb = snap_reg.sum_xy;
            end
            2'd2:
            begin
                opa = $signed(glit_pkg::OPA_W'(snap_reg.count));
                opb = $signed(OBW'(snap_reg.sum_y_sq));
            end
            default:
            begin
                opa = snap_reg.sum_y;
                opb = OBW'(snap_reg.sum_y);
            end
        endcase
    end

    // even steps take the upper half of the wide operand, odd steps the lower
    assign bpart = step_reg[0] ? $signed({1'b0, opb[HW-1:0]})
                               : (HW+1)'($signed(opb[OBW-1:HW]));

    assign term    = prod_hi_reg ? (AW'(prod_reg) <<< HW) : AW'(prod_reg);
    assign acc_sum = prod_neg_reg ? acc_reg - term : acc_reg + term;

    assign num_mag  = num_reg[AW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
    assign den_mag  = den_reg[glit_pkg::DEN_W-1] ? $unsigned(-den_reg) : $unsigned(den_reg);
    assign fit_fail = (den_reg == '0) || (snap_reg.count < glit_pkg::FIT_MIN_POINTS);

    assign err     = CMP_W'(pred_reg) - CMP_W'(keeper_reg);
    assign err_mag = err[CMP_W-1] ? $unsigned(-err) : $unsigned(err);
    assign move    = err_mag > CMP_W'(cfg.move_threshold);
    assign spd     = (cfg.drive_speed > glit_pkg::SPEED_LIMIT) ? glit_pkg::SPEED_LIMIT
                                                               : cfg.drive_speed;
    assign pred_ext = EXT_W'(pred_reg);

    assign load_out  = (state_reg == B_DEC) && (!out_valid_reg || out_ready);
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign div_start = (state_reg == B_DIV0) && !fit_fail;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (step_reg == DEN_DONE)
                begin
                    state_next = B_DIV0;
                end
            end
            B_DIV0:
            begin
                state_next = fit_fail ? B_DEC : B_DIV;
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    state_next = B_DEC;
                end
            end
            B_DEC:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    glit_div #(
        .POS_WIDTH (POS_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_mag[AW-2:0], 1'b0} + AW'(den_mag)),
        .divisor  ({den_mag[glit_pkg::DIVS_W-2:0], 1'b0}),
        .done     (div_done),
        .quot     (div_q),
        .sat      (div_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            keeper_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_MUL)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (move)
                begin
                    keeper_reg <= pred_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            snap_reg <= q_data;
            acc_reg  <= '0;
        end
        if (state_reg == B_MUL)
        begin
            prod_reg     <= opa * bpart;
            prod_hi_reg  <= !step_reg[0];
            prod_neg_reg <= step_reg[1];
            if (step_reg != '0)
            begin
                if (step_reg == NUM_DONE)
                begin
                    num_reg <= acc_sum;
                    acc_reg <= '0;
                end
                else if (step_reg == DEN_DONE)
                begin
                    den_reg <= glit_pkg::DEN_W'(acc_sum);
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
        end
        if (state_reg == B_DIV0)
        begin
            neg_reg <= num_reg[AW-1] ^ den_reg[glit_pkg::DEN_W-1];
            if (fit_fail)
            begin
                pred_reg <= POS_FAIL;
                ok_reg   <= 1'b0;
            end
        end
        if ((state_reg == B_DIV) && div_done)
        begin
            ok_reg <= 1'b1;
            if (neg_reg)
            begin
                pred_reg <= div_sat ? POS_MIN : -$signed(div_q);
            end
            else
            begin
                pred_reg <= div_sat ? POS_MAX : $signed(div_q);
            end
        end
        if (load_out)
        begin
            pred_out_reg <= pred_ext[glit_pkg::PRED_W-1:0];
            ok_out_reg   <= ok_reg;
            if (move)
            begin
                act_out_reg <= err[CMP_W-1] ? glit_pkg::ACT_LEFT : glit_pkg::ACT_RIGHT;
                if (spd != '0)
                begin
                    dir_out_reg  <= err[CMP_W-1] ? glit_pkg::DIR_REVERSE
                                                 : glit_pkg::DIR_FORWARD;
                    word_out_reg <= {spd, spd};
                end
                else
                begin
                    dir_out_reg  <= glit_pkg::DIR_STOP;
                    word_out_reg <= '0;
                end
            end
            else
            begin
                act_out_reg  <= glit_pkg::ACT_HOLD;
                dir_out_reg  <= glit_pkg::DIR_STOP;
                word_out_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign predicted_x = pred_out_reg;
    assign fit_ok      = ok_out_reg;
    assign action      = act_out_reg;
    assign dir_code    = dir_out_reg;
    assign speed_word  = word_out_reg;

    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_out_reg) |-> (pred_out_reg == glit_pkg::PRED_W'(glit_pkg::FAIL_POS)))
        else $error("failed fit without the fallback position");

    a_hold_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (act_out_reg == glit_pkg::ACT_HOLD))
            |-> ((dir_out_reg == glit_pkg::DIR_STOP) && (word_out_reg == '0)))
        else $error("hold result drives the motor");

endmodule
